/* rtl/core/mktd_pkg.sv */
// shared types and constants of the morse key timing decoder
`timescale 1ns / 1ps

package mktd_pkg;

	localparam int unsigned PATTERN_MAX  = 6;
	localparam int unsigned SENTENCE_MAX = 128;
	localparam int unsigned CFG_W        = 16;
	localparam int unsigned RUN_MAX      = 3;

	typedef enum logic [2:0] {
		EV_DOT      = 3'd0,
		EV_DASH     = 3'd1,
		EV_LETTER   = 3'd2,
		EV_SPACE    = 3'd3,
		EV_SENTENCE = 3'd4
	} event_kind_t;

	typedef enum logic [2:0] {
		CFG_DOT_LIMIT    = 3'd0,
		CFG_DASH_LIMIT   = 3'd1,
		CFG_LETTER_GAP   = 3'd2,
		CFG_WORD_GAP     = 3'd3,
		CFG_SENTENCE_GAP = 3'd4
	} cfg_index_t;

	localparam logic [CFG_W-1:0] DOT_LIMIT_RST    = 16'd300;
	localparam logic [CFG_W-1:0] DASH_LIMIT_RST   = 16'd900;
	localparam logic [CFG_W-1:0] LETTER_GAP_RST   = 16'd900;
	localparam logic [CFG_W-1:0] WORD_GAP_RST     = 16'd2100;
	localparam logic [CFG_W-1:0] SENTENCE_GAP_RST = 16'd3000;

	typedef struct packed {
		logic [CFG_W-1:0] dot_limit;
		logic [CFG_W-1:0] dash_limit;
		logic [CFG_W-1:0] letter_gap;
		logic [CFG_W-1:0] word_gap;
		logic [CFG_W-1:0] sentence_gap;
	} cfg_t;

	typedef struct packed {
		event_kind_t kind;
		logic [5:0]  pattern;
		logic [2:0]  length;
		logic [7:0]  sentence;
	} result_t;

endpackage

/* rtl/core/morse_key_timing_decoder.sv */
// Morse key timing decoder: one transaction in per millisecond tick, event results out.
// Input channel in_valid/in_ready carries key_down and clear_down for one tick.
// Output channel out_valid/out_ready carries one event: dot, dash, letter done,
// word space or sentence end, with the pattern and sentence length after it.
// A tick causes zero to three events; last_in_run marks the last one of a tick.
// The events of an accepted tick pass through the run buffer and then the output register.
// Throughput: one tick per cycle while ticks cause at most one event each and the
// receiver keeps out_ready high; a tick with more events holds the input until its last one leaves.
// The run buffer holding one tick's events is emptied through a single output
// register, so one event leaves per cycle while the receiver keeps out_ready high.
// A stalled receiver holds the output register; ticks are still taken until one
// with events fills the run buffer, after which in_ready drops until events drain.
// Configuration writes through cfg_write/cfg_addr/cfg_data take effect at once
// and are meant for idle periods only.
// Reset clears all timing state, the pattern and the sentence count, empties
// the result path and loads the default limits and gaps.
`timescale 1ns / 1ps

module morse_key_timing_decoder #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        key_down,
	input  logic        clear_down,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [5:0]  pattern_bits,
	output logic [2:0]  pattern_length,
	output logic [7:0]  sentence_length,
	output logic        last_in_run
);
	import mktd_pkg::*;

	cfg_t          cfg_q;
	logic          accept;
	logic [1:0]    run_count;
	result_t [2:0] run_res;
	result_t       out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_limit    <= DOT_LIMIT_RST;
			cfg_q.dash_limit   <= DASH_LIMIT_RST;
			cfg_q.letter_gap   <= LETTER_GAP_RST;
			cfg_q.word_gap     <= WORD_GAP_RST;
			cfg_q.sentence_gap <= SENTENCE_GAP_RST;
		end else if (cfg_write) begin
			case (cfg_addr)
				CFG_DOT_LIMIT:    cfg_q.dot_limit    <= cfg_data;
				CFG_DASH_LIMIT:   cfg_q.dash_limit   <= cfg_data;
				CFG_LETTER_GAP:   cfg_q.letter_gap   <= cfg_data;
				CFG_WORD_GAP:     cfg_q.word_gap     <= cfg_data;
				CFG_SENTENCE_GAP: cfg_q.sentence_gap <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	mktd_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.key_down   (key_down),
		.clear_down (clear_down),
		.run_count  (run_count),
		.run_res    (run_res)
	);

	mktd_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_count (run_count),
		.push_res   (run_res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res),
		.out_last   (last_in_run)
	);

	assign event_kind      = out_res.kind;
	assign pattern_bits    = out_res.pattern;
	assign pattern_length  = out_res.length;
	assign sentence_length = out_res.sentence;

endmodule

/* rtl/core/mktd_core.sv */
// timing state registers and per-tick event logic
`timescale 1ns / 1ps

module mktd_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mktd_pkg::cfg_t               cfg,
	input  logic                         accept,
	input  logic                         key_down,
	input  logic                         clear_down,
	output logic [1:0]                   run_count,
	output mktd_pkg::result_t [2:0]      run_res
);
	import mktd_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic                   key_was_down_q;
	logic [COUNT_WIDTH-1:0] press_q;
	logic [COUNT_WIDTH-1:0] idle_q;
	logic [5:0]             pattern_q;
	logic [2:0]             symbols_q;
	logic [7:0]             sentence_q;
	logic                   ends_space_q;

	logic                   key_was_down_d;
	logic [COUNT_WIDTH-1:0] press_d;
	logic [COUNT_WIDTH-1:0] idle_d;
	logic [5:0]             pattern_d;
	logic [2:0]             symbols_d;
	logic [7:0]             sentence_d;
	logic                   ends_space_d;

	always_comb begin
		logic [CMP_W-1:0] press_x;
		logic [CMP_W-1:0] idle_x;
		logic             is_dot;
		logic             is_dash;
		logic             ev_letter;
		logic             ev_space;
		logic             ev_end;
		logic [1:0]       n;

		key_was_down_d = key_was_down_q;
		press_d        = press_q;
		idle_d         = idle_q;
		pattern_d      = pattern_q;
		symbols_d      = symbols_q;
		sentence_d     = sentence_q;
		ends_space_d   = ends_space_q;
		n              = 2'd0;
		run_res        = '0;
		press_x        = CMP_W'(press_q);
		idle_x         = '0;
		is_dot         = 1'b0;
		is_dash        = 1'b0;
		ev_letter      = 1'b0;
		ev_space       = 1'b0;
		ev_end         = 1'b0;

		if (clear_down) begin
			key_was_down_d = 1'b0;
			press_d        = '0;
			idle_d         = '0;
			pattern_d      = '0;
			symbols_d      = '0;
			sentence_d     = '0;
			ends_space_d   = 1'b0;
		end else if (key_down) begin
			if (!key_was_down_q)
				press_d = COUNT_WIDTH'(1);
			else if (press_q != '1)
				press_d = press_q + COUNT_WIDTH'(1);
			key_was_down_d = 1'b1;
		end else if (key_was_down_q) begin
			// release tick: classify the press
			is_dot  = press_x < CMP_W'(cfg.dot_limit);
			is_dash = !is_dot && (press_x < CMP_W'(cfg.dash_limit));
			if ((is_dot || is_dash) && (symbols_q < 3'(PATTERN_MAX))) begin
				if (is_dash)
					pattern_d = pattern_q | (6'd1 << symbols_q);
				symbols_d           = symbols_q + 3'd1;
				run_res[0].kind     = is_dash ? EV_DASH : EV_DOT;
				run_res[0].pattern  = pattern_d;
				run_res[0].length   = symbols_d;
				run_res[0].sentence = sentence_q;
				n                   = 2'd1;
			end
			key_was_down_d = 1'b0;
			press_d        = '0;
			idle_d         = '0;
		end else begin
			if (idle_q != '1)
				idle_d = idle_q + COUNT_WIDTH'(1);
			idle_x = CMP_W'(idle_d);

			// gap events apply in order, each seeing the previous one's effect
			ev_letter = (symbols_q != 3'd0) && (idle_x >= CMP_W'(cfg.letter_gap));
			if (ev_letter) begin
				if (sentence_d < 8'(SENTENCE_MAX)) begin
					sentence_d   = sentence_d + 8'd1;
					ends_space_d = 1'b0;
				end
				run_res[n].kind     = EV_LETTER;
				run_res[n].pattern  = pattern_q;
				run_res[n].length   = symbols_q;
				run_res[n].sentence = sentence_d;
				n                   = n + 2'd1;
				pattern_d           = '0;
				symbols_d           = '0;
			end

			ev_space = (sentence_d != 8'd0) && (idle_x >= CMP_W'(cfg.word_gap))
				&& !ends_space_d && (sentence_d < 8'(SENTENCE_MAX));
			if (ev_space) begin
				sentence_d          = sentence_d + 8'd1;
				ends_space_d        = 1'b1;
				run_res[n].kind     = EV_SPACE;
				run_res[n].pattern  = pattern_d;
				run_res[n].length   = symbols_d;
				run_res[n].sentence = sentence_d;
				n                   = n + 2'd1;
			end

			ev_end = (sentence_d != 8'd0) && (idle_x >= CMP_W'(cfg.sentence_gap));
			if (ev_end) begin
				sentence_d          = '0;
				ends_space_d        = 1'b0;
				run_res[n].kind     = EV_SENTENCE;
				run_res[n].pattern  = pattern_d;
				run_res[n].length   = symbols_d;
				run_res[n].sentence = 8'd0;
				n                   = n + 2'd1;
			end
		end

		run_count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_was_down_q <= 1'b0;
			press_q        <= '0;
			idle_q         <= '0;
			pattern_q      <= '0;
			symbols_q      <= '0;
			sentence_q     <= '0;
			ends_space_q   <= 1'b0;
		end else if (accept) begin
			key_was_down_q <= key_was_down_d;
			press_q        <= press_d;
			idle_q         <= idle_d;
			pattern_q      <= pattern_d;
			symbols_q      <= symbols_d;
			sentence_q     <= sentence_d;
			ends_space_q   <= ends_space_d;
		end
	end

endmodule

/* rtl/core/mktd_drain.sv */
// run buffer for the results of one tick and the output register
`timescale 1ns / 1ps

module mktd_drain (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [1:0]              push_count,
	input  mktd_pkg::result_t [2:0] push_res,
	output logic                    push_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output mktd_pkg::result_t       out_res,
	output logic                    out_last
);
	import mktd_pkg::*;

	result_t [2:0] run_q;
	logic [1:0]    count_q;
	logic [1:0]    idx_q;
	logic          ovalid_q;
	result_t       ores_q;
	logic          olast_q;

	logic run_busy;
	logic take;
	logic take_last;

	assign run_busy   = count_q != 2'd0;
	assign take       = run_busy && (!ovalid_q || out_ready);
	assign take_last  = take && (idx_q == count_q - 2'd1);
	// a new tick may enter while the last result of the run moves out
	assign push_ready = !run_busy || take_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			// a push only comes when the buffer is empty or its last result leaves
			if (push && push_count != 2'd0) begin
				count_q <= push_count;
				idx_q   <= 2'd0;
			end else if (take) begin
				if (take_last) begin
					count_q <= 2'd0;
					idx_q   <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ores_q  <= run_q[idx_q];
			olast_q <= take_last;
		end
		if (push && push_count != 2'd0)
			run_q <= push_res;
	end

	assign out_valid = ovalid_q;
	assign out_res   = ores_q;
	assign out_last  = olast_q;

endmodule
